/* hdl/pfc_pkg.sv */
`default_nettype none

package pfc_pkg;

    // Source formats.
    localparam logic [1:0] FMT_RGB565 = 2'd0;
    localparam logic [1:0] FMT_RGB555 = 2'd1;
    localparam logic [1:0] FMT_RGB32  = 2'd2;
    localparam logic [1:0] FMT_YUY2   = 2'd3;

    // Destination depths.
    localparam logic [1:0] DEP_16       = 2'd0;
    localparam logic [1:0] DEP_24       = 2'd1;
    localparam logic [1:0] DEP_32       = 2'd2;
    localparam logic [1:0] DEP_RESERVED = 2'd3;

    // Register indexes.
    localparam logic [1:0] REG_SOURCE_FORMAT = 2'd0;
    localparam logic [1:0] REG_TARGET_DEPTH  = 2'd1;

    // Q12 coefficients.
    localparam int CoefVB = 4669;
    localparam int CoefUG = 1618;
    localparam int CoefVG = 2380;
    localparam int CoefUR = 8323;

    localparam int SumW = 23;

    // Chroma products, shared by both lanes.
    typedef struct packed {
        logic signed [SumW-1:0] vb;
        logic signed [SumW-1:0] ug;
        logic signed [SumW-1:0] vg;
        logic signed [SumW-1:0] ur;
    } t_chroma;

    typedef struct packed {
        logic [7:0] cb;
        logic [7:0] cg;
        logic [7:0] cr;
    } t_rgb;

    typedef struct packed {
        logic        unsupported;
        logic [1:0]  pixel_count;
        logic [31:0] second_pixel;
        logic [31:0] first_pixel;
    } t_result;

endpackage

`default_nettype wire

/* hdl/pfc_lane.sv */
`default_nettype none

module pfc_lane
    import pfc_pkg::*;
(
    input  wire logic signed [8:0] i_y,
    input  wire t_chroma           i_chroma,
    output t_rgb                   o_rgb
);

    logic signed [SumW-1:0] y_q12;
    logic signed [SumW-1:0] s_b;
    logic signed [SumW-1:0] s_g;
    logic signed [SumW-1:0] s_r;

    function automatic logic [7:0] sat_q12(input logic signed [SumW-1:0] s);
        logic [7:0] v;
        if (s <= 0) begin
            v = 8'd0;
        end else if (|s[SumW-2:20]) begin
            v = 8'hFF;
        end else begin
            v = s[19:12];
        end
        return v;
    endfunction

    assign y_q12 = {{(SumW-21){i_y[8]}}, i_y, 12'd0};
    assign s_b   = y_q12 + i_chroma.vb;
    assign s_g   = y_q12 - i_chroma.ug - i_chroma.vg;
    assign s_r   = y_q12 + i_chroma.ur;

    assign o_rgb.cb = sat_q12(s_b);
    assign o_rgb.cg = sat_q12(s_g);
    assign o_rgb.cr = sat_q12(s_r);

endmodule

`default_nettype wire

/* hdl/pfc_merge.sv */
`default_nettype none

module pfc_merge
    import pfc_pkg::*;
(
    input  wire logic [1:0]  i_fmt,
    input  wire logic [1:0]  i_dep,
    input  wire logic [31:0] i_word,
    input  wire t_rgb        i_lane0,
    input  wire t_rgb        i_lane1,
    output t_result          o_result
);

    function automatic logic [31:0] pack_rgb(input t_rgb c, input logic [1:0] dep);
        logic [31:0] p;
        if (dep == DEP_16) begin
            p = {16'd0, c.cb[7:3], c.cg[7:2], c.cr[7:3]};
        end else begin
            p = {8'd0, c.cb, c.cg, c.cr};
        end
        return p;
    endfunction

    always_comb begin
        o_result = '0;
        case (i_fmt)
            FMT_YUY2: begin
                if (i_dep == DEP_RESERVED) begin
                    o_result.unsupported = 1'b1;
                end else begin
                    o_result.first_pixel  = pack_rgb(i_lane0, i_dep);
                    o_result.second_pixel = pack_rgb(i_lane1, i_dep);
                    o_result.pixel_count  = 2'd2;
                end
            end
            FMT_RGB32: begin
                if (i_dep == DEP_32) begin
                    o_result.first_pixel = i_word;
                    o_result.pixel_count = 2'd1;
                end else begin
                    o_result.unsupported = 1'b1;
                end
            end
            default: begin
                if (i_dep == DEP_16) begin
                    o_result.first_pixel = {16'd0, i_word[15:0]};
                    o_result.pixel_count = 2'd1;
                end else if (i_dep == DEP_32) begin
                    if (i_fmt == FMT_RGB565) begin
                        o_result.first_pixel = {8'd0, i_word[15:11], 3'd0,
                                                i_word[10:5], 2'd0, i_word[4:0], 3'd0};
                    end else begin
                        o_result.first_pixel = {8'd0, i_word[14:10], 3'd0,
                                                i_word[9:5], 3'd0, i_word[4:0], 3'd0};
                    end
                    o_result.pixel_count = 2'd1;
                end else begin
                    o_result.unsupported = 1'b1;
                end
            end
        endcase
    end

endmodule

`default_nettype wire

/* hdl/pixel_format_converter.sv */
`default_nettype none

// Channel   Dir  Handshake                        Payload
// s_axis    in   i_s_axis_tvalid/o_s_axis_tready  tdata: source_word
// m_axis    out  o_m_axis_tvalid/i_m_axis_tready  tdata: first, second, count; tuser: unsupported
// cfg       in   i_cfg_we (no handshake back)     i_cfg_addr, i_cfg_data
//
// One word per clock sustained while the output is not stalled.
// The first stage registers the four chroma products; the second forms the
// two lane sums, clips them and packs the result into the output register.
// Each stage advances when the stage after it is empty or moving, so input
// is still taken while a finished result waits, as long as the first stage is
// empty. Reset is synchronous and empties both stages and restores the register defaults.
module pixel_format_converter
    import pfc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [31:0] i_s_axis_tdata,   // [31:0] source_word
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [71:0]      o_m_axis_tdata,   // [31:0] first_pixel, [63:32] second_pixel,
                                               // [65:64] pixel_count, [71:66] zero
    output logic             o_m_axis_tuser,   // [0] unsupported
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_addr,
    input  wire logic [1:0]  i_cfg_data
);

    logic [1:0]  r_fmt;
    logic [1:0]  r_dep;

    logic              r_v1;
    logic [31:0]       r_word;
    logic signed [8:0] r_y0;
    logic signed [8:0] r_y1;
    t_chroma           r_chroma;

    logic        r_vo;
    t_result     r_result;

    logic        out_ready;
    logic        s1_ready;
    logic        in_xfer;
    logic signed [8:0] u;
    logic signed [8:0] v;
    t_chroma     n_chroma;
    t_rgb        lane0;
    t_rgb        lane1;
    t_result     n_result;

    assign out_ready       = !r_vo || i_m_axis_tready;
    assign s1_ready        = !r_v1 || out_ready;
    assign o_s_axis_tready = s1_ready;
    assign in_xfer         = i_s_axis_tvalid && s1_ready;

    assign u = $signed({1'b0, i_s_axis_tdata[15:8]})  - 9'sd128;
    assign v = $signed({1'b0, i_s_axis_tdata[31:24]}) - 9'sd128;

    assign n_chroma.vb = SumW'(v * $signed(SumW'(CoefVB)));
    assign n_chroma.ug = SumW'(u * $signed(SumW'(CoefUG)));
    assign n_chroma.vg = SumW'(v * $signed(SumW'(CoefVG)));
    assign n_chroma.ur = SumW'(u * $signed(SumW'(CoefUR)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt <= FMT_RGB565;
            r_dep <= DEP_32;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_SOURCE_FORMAT: r_fmt <= i_cfg_data;
                REG_TARGET_DEPTH:  r_dep <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (s1_ready) begin
            r_v1 <= i_s_axis_tvalid;
        end
        if (in_xfer) begin
            r_word   <= i_s_axis_tdata;
            r_y0     <= $signed({1'b0, i_s_axis_tdata[7:0]})   - 9'sd16;
            r_y1     <= $signed({1'b0, i_s_axis_tdata[23:16]}) - 9'sd16;
            r_chroma <= n_chroma;
        end
    end

    pfc_lane u_lane0 (.i_y(r_y0), .i_chroma(r_chroma), .o_rgb(lane0));
    pfc_lane u_lane1 (.i_y(r_y1), .i_chroma(r_chroma), .o_rgb(lane1));

    pfc_merge u_merge (
        .i_fmt    (r_fmt),
        .i_dep    (r_dep),
        .i_word   (r_word),
        .i_lane0  (lane0),
        .i_lane1  (lane1),
        .o_result (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vo <= 1'b0;
        end else if (out_ready) begin
            r_vo <= r_v1;
        end
        if (out_ready && r_v1) begin
            r_result <= n_result;
        end
    end

    assign o_m_axis_tvalid = r_vo;
    assign o_m_axis_tdata  = {6'd0, r_result.pixel_count, r_result.second_pixel,
                              r_result.first_pixel};
    assign o_m_axis_tuser  = r_result.unsupported;

    // Input back-pressure only arises with the first stage holding an item.
    a_ready_low_means_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> r_v1)
        else $error("input stalled with first stage empty");

    // An unsupported combination carries no pixels.
    a_unsupported_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser) |->
            (o_m_axis_tdata[65:64] == 2'd0 && o_m_axis_tdata[63:0] == 64'd0))
        else $error("unsupported result carries pixels");

    // The second pixel is zero unless a pair was produced.
    a_second_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tdata[65:64] != 2'd2) |->
            (o_m_axis_tdata[63:32] == 32'd0))
        else $error("second pixel set without a pair");

    // A result that enters the output register comes from an occupied first stage.
    a_out_from_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_vo || i_m_axis_tready) && !r_v1 |=> !r_vo)
        else $error("result appeared without an item");

endmodule

`default_nettype wire
